// File: sv/cppm_pkg.sv
// shared types and constants of the cppm channel decoder
package cppm_pkg;

    // request kinds carried on req_type
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_SYNC_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_RESYNC_LIMIT   = 3'd1;
    localparam logic [2:0] REG_MIN_WIDTH      = 3'd2;
    localparam logic [2:0] REG_MAX_WIDTH      = 3'd3;
    localparam logic [2:0] REG_RAMP_RATE      = 3'd4;
    localparam logic [2:0] REG_RAMP_ENABLE    = 3'd5;
    localparam logic [2:0] REG_OFFSET_ENABLE  = 3'd6;
    localparam logic [2:0] REG_OUTPUT_OFFSET  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CHAN_W     = 4;
    localparam int CHAN_DEPTH = 16;

    // channel value seen before any ramp update
    localparam logic [WIDTH_W-1:0] MID_PULSE = 16'd1500;

    // ramp limiter: delta = ramp_rate * elapsed / RAMP_PERIOD_US
    localparam int RAMP_PERIOD_US = 20000;
    localparam int PROD_W         = WIDTH_W + TIME_W;
    // a product below PROD_SAT fits in this many bits
    localparam int REM_W          = 31;
    // product at or above this gives a delta that no longer limits anything
    localparam logic [PROD_W-1:0] PROD_SAT = 48'(RAMP_PERIOD_US * 65535);

    // divide by 20000 as a shift by 5 and a divide by 625
    localparam int PRE_SHIFT   = 5;
    localparam int RED_W       = REM_W - PRE_SHIFT;
    // ceil(2^34 / 625), exact for every dividend below 2^26
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_625 = 25'd27487791;
    localparam int QPROD_W     = RED_W + RECIP_W;

    typedef struct packed {
        logic [WIDTH_W-1:0] sync_threshold;
        logic [7:0]         resync_limit;
        logic [WIDTH_W-1:0] min_width;
        logic [WIDTH_W-1:0] max_width;
        logic [WIDTH_W-1:0] ramp_rate;
        logic               ramp_enable;
        logic               offset_enable;
        logic [WIDTH_W-1:0] output_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sync_threshold: 16'd3000,
        resync_limit:   8'd16,
        min_width:      16'd1000,
        max_width:      16'd2000,
        ramp_rate:      16'd100,
        ramp_enable:    1'b0,
        offset_enable:  1'b0,
        output_offset:  16'd0
    };

endpackage

// File: sv/cppm_channel_decoder.sv
// cppm_channel_decoder: combined ppm decoder top level with slot ring and channel memories
// An edge word is written into the slot ring and gives no result. A read word makes k
// single-slot sync advances (at most resync_limit, one per cycle through the ring memory
// read port) and w CHANNEL_SLOTS subtractions to wrap sync + channel (zero for any
// channel below CHANNEL_SLOTS - sync), then fetches the slot and writes the result. The
// ramp limiter adds a multiply, a divide by 20000 through a reciprocal multiply and an
// update step. A result waits in an output register, and the block takes new words while
// it waits; a second read result holds in the last stage until the first is taken. No
// clearing pass is needed after reset: slots and channel entries carry valid bits.
module cppm_channel_decoder #(
    parameter int CHANNEL_SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [cppm_pkg::TIME_W-1:0]         time_us,
    input  logic [cppm_pkg::CHAN_W-1:0]         channel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cppm_pkg::WIDTH_W-1:0]        pulse_width,
    input  logic                                cfg_write,
    input  logic [cppm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cppm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cppm_pkg::*;

    localparam int SLOT_W = $clog2(CHANNEL_SLOTS);
    localparam int SUM_W  = $clog2(CHANNEL_SLOTS + 15);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNEL_SLOTS - 1);
    localparam logic [SUM_W-1:0]  RING_LEN  = SUM_W'(CHANNEL_SLOTS);

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEEK  = 4'd1;
    localparam logic [3:0] S_WRAP  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_LIMIT = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;

    // control state
    logic [3:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   sync_reg, sync_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [WIDTH_W-1:0]  last_edge_reg, last_edge_next;
    logic [7:0]          seek_cnt_reg, seek_cnt_next;
    logic                out_valid_reg, out_valid_next;
    cfg_t                cfg_reg, cfg_next;

    // datapath registers
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SUM_W-1:0]    slot_sum_reg, slot_sum_next;
    logic [WIDTH_W-1:0]  val_reg, val_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [WIDTH_W-1:0]  q_reg, q_next;
    logic                sat_reg, sat_next;
    logic [WIDTH_W-1:0]  out_data_reg, out_data_next;

    // slot ring memory
    logic [WIDTH_W-1:0]        ring_mem [CHANNEL_SLOTS];
    logic [CHANNEL_SLOTS-1:0]  ring_vld_reg;
    logic [WIDTH_W-1:0]        ring_rdata_reg;
    logic                      ring_rvld_reg;
    logic [SLOT_W-1:0]         ring_raddr;
    logic                      ring_we;
    logic [WIDTH_W-1:0]        ring_wdata;

    // per-channel ramp memories
    logic [WIDTH_W-1:0]        prev_mem [CHAN_DEPTH];
    logic [TIME_W-1:0]         time_mem [CHAN_DEPTH];
    logic [CHAN_DEPTH-1:0]     chan_vld_reg;
    logic [WIDTH_W-1:0]        prev_rdata_reg;
    logic [TIME_W-1:0]         time_rdata_reg;
    logic                      chan_rvld_reg;
    logic [CHAN_W-1:0]         chan_raddr;
    logic                      chan_we;

    // datapath helpers
    logic                      in_fire;
    logic [WIDTH_W-1:0]        ring_word;
    logic [WIDTH_W-1:0]        prev_word;
    logic [TIME_W-1:0]         last_read;
    logic [TIME_W-1:0]         elapsed;
    logic [SLOT_W-1:0]         sync_inc;
    logic [QPROD_W-1:0]        quot_prod;
    logic [WIDTH_W-1:0]        delta;
    logic [WIDTH_W-1:0]        ramp_lo;
    logic [WIDTH_W:0]          ramp_hi_sum;
    logic [WIDTH_W-1:0]        ramp_hi;
    logic [WIDTH_W-1:0]        clamped;
    logic [WIDTH_W:0]          offset_sum;
    logic [WIDTH_W-1:0]        final_word;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign pulse_width = out_data_reg;

    // memory read views with reset values for unwritten entries
    assign ring_word = ring_rvld_reg ? ring_rdata_reg : '0;
    assign prev_word = chan_rvld_reg ? prev_rdata_reg : MID_PULSE;
    assign last_read = chan_rvld_reg ? time_rdata_reg : '0;
    assign elapsed   = time_reg - last_read;
    assign sync_inc  = (sync_reg == LAST_SLOT) ? '0 : sync_reg + 1'b1;

    // divide by 20000: drop five bits, then multiply by the reciprocal of 625
    assign quot_prod = QPROD_W'(prod_reg[REM_W-1:PRE_SHIFT]) * QPROD_W'(RECIP_625);

    // ramp bounds around the previous output
    assign delta       = sat_reg ? '1 : q_reg;
    assign ramp_lo     = (delta >= prev_word) ? '0 : prev_word - delta;
    assign ramp_hi_sum = {1'b0, prev_word} + {1'b0, delta};
    assign ramp_hi     = ramp_hi_sum[WIDTH_W] ? '1 : ramp_hi_sum[WIDTH_W-1:0];

    // clamp and saturating offset
    always_comb
    begin
        if (val_reg < cfg_reg.min_width)
        begin
            clamped = cfg_reg.min_width;
        end
        else if (val_reg > cfg_reg.max_width)
        begin
            clamped = cfg_reg.max_width;
        end
        else
        begin
            clamped = val_reg;
        end
        offset_sum = {1'b0, clamped} + {1'b0, cfg_reg.output_offset};
        if (!cfg_reg.offset_enable)
        begin
            final_word = clamped;
        end
        else if (offset_sum[WIDTH_W])
        begin
            final_word = '1;
        end
        else
        begin
            final_word = offset_sum[WIDTH_W-1:0];
        end
    end

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SYNC_THRESHOLD: cfg_next.sync_threshold = cfg_data;
                REG_RESYNC_LIMIT:   cfg_next.resync_limit   = cfg_data[7:0];
                REG_MIN_WIDTH:      cfg_next.min_width      = cfg_data;
                REG_MAX_WIDTH:      cfg_next.max_width      = cfg_data;
                REG_RAMP_RATE:      cfg_next.ramp_rate      = cfg_data;
                REG_RAMP_ENABLE:    cfg_next.ramp_enable    = cfg_data[0];
                REG_OFFSET_ENABLE:  cfg_next.offset_enable  = cfg_data[0];
                REG_OUTPUT_OFFSET:  cfg_next.output_offset  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sync_next      = sync_reg;
        wslot_next     = wslot_reg;
        last_edge_next = last_edge_reg;
        seek_cnt_next  = seek_cnt_reg;
        chan_next      = chan_reg;
        time_next      = time_reg;
        slot_sum_next  = slot_sum_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ring_raddr     = sync_reg;
        ring_we        = 1'b0;
        ring_wdata     = time_us[WIDTH_W-1:0] - last_edge_reg;
        chan_raddr     = chan_reg;
        chan_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                chan_raddr = channel;
                if (in_fire)
                begin
                    if (req_type == REQ_EDGE)
                    begin
                        ring_we        = 1'b1;
                        last_edge_next = time_us[WIDTH_W-1:0];
                        wslot_next     = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + 1'b1;
                    end
                    else
                    begin
                        chan_next     = channel;
                        time_next     = time_us;
                        seek_cnt_next = '0;
                        state_next    = S_SEEK;
                    end
                end
            end

            // one sync advance per cycle, read of the next slot issued ahead
            S_SEEK:
            begin
                if ((seek_cnt_reg == cfg_reg.resync_limit) ||
                    (ring_word > cfg_reg.sync_threshold))
                begin
                    slot_sum_next = SUM_W'(sync_reg) + SUM_W'(chan_reg);
                    state_next    = S_WRAP;
                end
                else
                begin
                    sync_next     = sync_inc;
                    ring_raddr    = sync_inc;
                    seek_cnt_next = seek_cnt_reg + 1'b1;
                end
            end

            // reduce sync + channel into the ring
            S_WRAP:
            begin
                if (slot_sum_reg >= RING_LEN)
                begin
                    slot_sum_next = slot_sum_reg - RING_LEN;
                end
                else
                begin
                    ring_raddr = slot_sum_reg[SLOT_W-1:0];
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                val_next   = ring_word;
                state_next = cfg_reg.ramp_enable ? S_MUL : S_FINAL;
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(cfg_reg.ramp_rate) * PROD_W'(elapsed);
                state_next = S_PREP;
            end

            // quotient by 20000, or saturation when it no longer limits
            S_PREP:
            begin
                sat_next   = (prod_reg >= PROD_SAT);
                q_next     = quot_prod[RECIP_SHIFT +: WIDTH_W];
                state_next = S_LIMIT;
            end

            // bound the change and write the channel entry back
            S_LIMIT:
            begin
                if (val_reg < ramp_lo)
                begin
                    val_next = ramp_lo;
                end
                else if (val_reg > ramp_hi)
                begin
                    val_next = ramp_hi;
                end
                chan_we    = 1'b1;
                state_next = S_FINAL;
            end

            S_FINAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = final_word;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sync_reg      <= '0;
            wslot_reg     <= '0;
            last_edge_reg <= '0;
            seek_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= CFG_RESET;
            ring_vld_reg  <= '0;
            ring_rvld_reg <= 1'b0;
            chan_vld_reg  <= '0;
            chan_rvld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sync_reg      <= sync_next;
            wslot_reg     <= wslot_next;
            last_edge_reg <= last_edge_next;
            seek_cnt_reg  <= seek_cnt_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            ring_rvld_reg <= ring_vld_reg[ring_raddr];
            chan_rvld_reg <= chan_vld_reg[chan_raddr];
            if (ring_we)
            begin
                ring_vld_reg[wslot_reg] <= 1'b1;
            end
            if (chan_we)
            begin
                chan_vld_reg[chan_reg] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        chan_reg     <= chan_next;
        time_reg     <= time_next;
        slot_sum_reg <= slot_sum_next;
        val_reg      <= val_next;
        prod_reg     <= prod_next;
        q_reg        <= q_next;
        sat_reg      <= sat_next;
        out_data_reg <= out_data_next;
    end

    // slot ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wslot_reg] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    // channel memories
    always_ff @(posedge clk)
    begin
        if (chan_we)
        begin
            prev_mem[chan_reg] <= val_next;
            time_mem[chan_reg] <= time_reg;
        end
        prev_rdata_reg <= prev_mem[chan_raddr];
        time_rdata_reg <= time_mem[chan_raddr];
    end

endmodule

// File: sv/cppm_checker.sv
// port-level checks of the cppm channel decoder and their bind
module cppm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             req_type,
    input logic [cppm_pkg::TIME_W-1:0]      time_us,
    input logic [cppm_pkg::CHAN_W-1:0]      channel,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [cppm_pkg::WIDTH_W-1:0]     pulse_width,
    input logic                             cfg_write,
    input logic [cppm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [cppm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cppm_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_width))
    else $error("result word changed while stalled");

    // a read word leaves the input side busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_READ) |=> !in_ready)
    else $error("input ready right after a read word");

    // an edge word leaves the input side ready in the next cycle and makes no result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_EDGE) && !out_valid |=> in_ready && !out_valid)
    else $error("edge word produced a result or stalled");

    // a new result only appears while a read is being worked
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no read in progress");

endmodule

bind cppm_channel_decoder cppm_checker u_cppm_checker (.*);
